### rtl/core/tlsx_pkg.sv
// Shared types, codes and constants for the TLS extensions block parser.
// No dependencies; used by tlsx_core, tlsx_res_fifo and tls_extension_block_parser.
`timescale 1ns / 1ps

package tlsx_pkg;

    // default cap on srtp profiles reported per extension
    localparam int MAX_PROFILES_DEF = 16;

    // extension header is type(2) + length(2)
    localparam logic [15:0] HDR_BYTES = 16'd4;

    // extension types handled in detail
    localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
    localparam logic [15:0] EXT_SRTP_PROF   = 16'd14;

    // result item kinds
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_NTYPE   = 3'd1,
        KIND_HOST    = 3'd2,
        KIND_PROFILE = 3'd3,
        KIND_ERROR   = 3'd4,
        KIND_DONE    = 3'd5
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_EXT_LONG   = 3'd1,
        ERR_LIST_LONG  = 3'd2,
        ERR_HOST_SHORT = 3'd3,
        ERR_PROF_DROP  = 3'd4
    } err_t;

    // one result transaction
    typedef struct packed {
        kind_t       kind;
        logic [15:0] ext_type;
        logic [15:0] ext_length;
        logic [15:0] value;
        err_t        err;
        logic        last;
    } result_t;

    // build a result; done items carry no extension type or length
    function automatic result_t make_result(kind_t kind, logic [15:0] ext_type,
                                            logic [15:0] ext_length, logic [15:0] value,
                                            err_t err, logic last);
        result_t r;
        r.kind       = kind;
        r.ext_type   = (kind == KIND_DONE) ? 16'd0 : ext_type;
        r.ext_length = (kind == KIND_DONE) ? 16'd0 : ext_length;
        r.value      = value;
        r.err        = err;
        r.last       = last;
        return r;
    endfunction

endpackage

### rtl/core/tlsx_core.sv
// Byte-step parser: phase and counter registers plus the per-byte next-state logic.
// Depends on tlsx_pkg; emits up to two results per byte toward tlsx_res_fifo.
`timescale 1ns / 1ps

module tlsx_core #(
    parameter int MAX_PROFILES = tlsx_pkg::MAX_PROFILES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              block_start,
    input  logic [15:0]       block_length,
    output logic [1:0]        res_vld,
    output tlsx_pkg::result_t res0,
    output tlsx_pkg::result_t res1
);

    // room for MAX_PROFILES plus the one overflow error step
    localparam int PCW = $clog2(MAX_PROFILES + 2);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_HDR0   = 4'd1,
        PH_HDR1   = 4'd2,
        PH_HDR2   = 4'd3,
        PH_HDR3   = 4'd4,
        PH_SKIP   = 4'd5,
        PH_LIST0  = 4'd6,
        PH_LIST1  = 4'd7,
        PH_NTYPE  = 4'd8,
        PH_NLEN0  = 4'd9,
        PH_NLEN1  = 4'd10,
        PH_HOST   = 4'd11,
        PH_PROF0  = 4'd12,
        PH_PROF1  = 4'd13,
        PH_TAIL   = 4'd14,
        PH_FAILED = 4'd15
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        block_left_reg, block_left_next;
    logic [15:0]        ext_left_reg, ext_left_next;
    logic [15:0]        cur_type_reg, cur_type_next;
    logic [15:0]        cur_len_reg, cur_len_next;
    logic [7:0]         high_byte_reg, high_byte_next;
    logic [15:0]        name_left_reg, name_left_next;
    logic [PCW-1:0]     prof_cnt_reg, prof_cnt_next;
    logic               block_failed_reg, block_failed_next;

    logic               in_ext;
    logic               zero_done;
    logic [15:0]        word;

    // one byte step
    always_comb
    begin
        phase_next        = phase_reg;
        block_left_next   = block_left_reg;
        ext_left_next     = ext_left_reg;
        cur_type_next     = cur_type_reg;
        cur_len_next      = cur_len_reg;
        high_byte_next    = high_byte_reg;
        name_left_next    = name_left_reg;
        prof_cnt_next     = prof_cnt_reg;
        block_failed_next = block_failed_reg;
        res_vld           = 2'b00;
        res0              = '0;
        res1              = '0;
        in_ext            = 1'b0;
        zero_done         = 1'b0;
        word              = {high_byte_reg, data_byte};

        if (step_en)
        begin
            // new block: clear everything, empty block finishes at once
            if (block_start)
            begin
                phase_next        = PH_IDLE;
                block_left_next   = '0;
                ext_left_next     = '0;
                cur_type_next     = '0;
                cur_len_next      = '0;
                high_byte_next    = '0;
                name_left_next    = '0;
                prof_cnt_next     = '0;
                block_failed_next = 1'b0;
                word              = {8'd0, data_byte};
                if (block_length == 16'd0)
                begin
                    res_vld[0] = 1'b1;
                    res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_DONE, 16'd0, 16'd0, 16'd0,
                                                 tlsx_pkg::ERR_NONE, 1'b1);
                    zero_done = 1'b1;
                end
                else
                begin
                    block_left_next = block_length;
                    phase_next = (block_length >= tlsx_pkg::HDR_BYTES) ? PH_HDR0 : PH_TAIL;
                end
            end

            if (!zero_done && phase_next != PH_IDLE)
            begin
                block_left_next = block_left_next - 16'd1;
                in_ext = (phase_next >= PH_SKIP) && (phase_next <= PH_PROF1);
                if (in_ext)
                begin
                    ext_left_next = ext_left_next - 16'd1;
                end

                case (phase_next)
                    PH_HDR0:
                    begin
                        high_byte_next = data_byte;
                        phase_next     = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        cur_type_next = word;
                        phase_next    = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        high_byte_next = data_byte;
                        phase_next     = PH_HDR3;
                    end
                    PH_HDR3:
                    begin
                        cur_len_next = word;
                        res_vld[0]   = 1'b1;
                        if (word > block_left_next)
                        begin
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_ERROR, cur_type_next,
                                                         word, 16'd0,
                                                         tlsx_pkg::ERR_EXT_LONG, 1'b1);
                            block_failed_next = 1'b1;
                            phase_next        = PH_FAILED;
                        end
                        else
                        begin
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_HEADER, cur_type_next,
                                                         word, 16'd0,
                                                         tlsx_pkg::ERR_NONE, 1'b0);
                            ext_left_next = word;
                            prof_cnt_next = '0;
                            in_ext        = 1'b1;
                            if (cur_type_next == tlsx_pkg::EXT_SERVER_NAME)
                            begin
                                phase_next = PH_LIST0;
                            end
                            else if (cur_type_next == tlsx_pkg::EXT_SRTP_PROF)
                            begin
                                phase_next = PH_PROF0;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_LIST0:
                    begin
                        high_byte_next = data_byte;
                        phase_next     = PH_LIST1;
                    end
                    PH_LIST1:
                    begin
                        if (word > ext_left_next)
                        begin
                            res_vld[0] = 1'b1;
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_ERROR, cur_type_next,
                                                         cur_len_next, 16'd0,
                                                         tlsx_pkg::ERR_LIST_LONG, 1'b1);
                            block_failed_next = 1'b1;
                            phase_next        = PH_FAILED;
                        end
                        else
                        begin
                            phase_next = PH_NTYPE;
                        end
                    end
                    PH_NTYPE:
                    begin
                        res_vld[0] = 1'b1;
                        res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_NTYPE, cur_type_next,
                                                     cur_len_next, {8'd0, data_byte},
                                                     tlsx_pkg::ERR_NONE, 1'b0);
                        phase_next = PH_NLEN0;
                    end
                    PH_NLEN0:
                    begin
                        high_byte_next = data_byte;
                        phase_next     = PH_NLEN1;
                    end
                    PH_NLEN1:
                    begin
                        // host length past the extension: flag it and skip the rest
                        if (word > ext_left_next)
                        begin
                            res_vld[0] = 1'b1;
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_ERROR, cur_type_next,
                                                         cur_len_next, 16'd0,
                                                         tlsx_pkg::ERR_HOST_SHORT, 1'b0);
                            name_left_next = '0;
                            phase_next     = PH_SKIP;
                        end
                        else
                        begin
                            name_left_next = word;
                            phase_next     = (word == 16'd0) ? PH_SKIP : PH_HOST;
                        end
                    end
                    PH_HOST:
                    begin
                        res_vld[0] = 1'b1;
                        res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_HOST, cur_type_next,
                                                     cur_len_next, {8'd0, data_byte},
                                                     tlsx_pkg::ERR_NONE, 1'b0);
                        name_left_next = name_left_next - 16'd1;
                        if (name_left_next == 16'd0)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_PROF0:
                    begin
                        high_byte_next = data_byte;
                        phase_next     = PH_PROF1;
                    end
                    PH_PROF1:
                    begin
                        // profiles up to the cap, one drop error, then silence
                        if (prof_cnt_next < PCW'(MAX_PROFILES))
                        begin
                            res_vld[0] = 1'b1;
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_PROFILE, cur_type_next,
                                                         cur_len_next, word,
                                                         tlsx_pkg::ERR_NONE, 1'b0);
                            prof_cnt_next = prof_cnt_next + PCW'(1);
                        end
                        else if (prof_cnt_next == PCW'(MAX_PROFILES))
                        begin
                            res_vld[0] = 1'b1;
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_ERROR, cur_type_next,
                                                         cur_len_next, 16'd0,
                                                         tlsx_pkg::ERR_PROF_DROP, 1'b0);
                            prof_cnt_next = prof_cnt_next + PCW'(1);
                        end
                        phase_next = PH_PROF0;
                    end
                    default:
                    begin
                    end
                endcase

                // extension consumed: next header or short tail
                if (in_ext && phase_next != PH_FAILED && ext_left_next == 16'd0)
                begin
                    phase_next = (block_left_next >= tlsx_pkg::HDR_BYTES) ? PH_HDR0 : PH_TAIL;
                end

                // block consumed: done item unless it already failed
                if (block_left_next == 16'd0)
                begin
                    if (!block_failed_next)
                    begin
                        if (res_vld[0])
                        begin
                            res_vld[1] = 1'b1;
                            res1 = tlsx_pkg::make_result(tlsx_pkg::KIND_DONE, 16'd0, 16'd0,
                                                         16'd0, tlsx_pkg::ERR_NONE, 1'b1);
                        end
                        else
                        begin
                            res_vld[0] = 1'b1;
                            res0 = tlsx_pkg::make_result(tlsx_pkg::KIND_DONE, 16'd0, 16'd0,
                                                         16'd0, tlsx_pkg::ERR_NONE, 1'b1);
                        end
                    end
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            block_left_reg   <= '0;
            ext_left_reg     <= '0;
            cur_type_reg     <= '0;
            cur_len_reg      <= '0;
            high_byte_reg    <= '0;
            name_left_reg    <= '0;
            prof_cnt_reg     <= '0;
            block_failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            block_left_reg   <= block_left_next;
            ext_left_reg     <= ext_left_next;
            cur_type_reg     <= cur_type_next;
            cur_len_reg      <= cur_len_next;
            high_byte_reg    <= high_byte_next;
            name_left_reg    <= name_left_next;
            prof_cnt_reg     <= prof_cnt_next;
            block_failed_reg <= block_failed_next;
        end
    end

    // second slot only ever carries the block-done item behind another result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_vld[1] |-> res_vld[0] && res1.kind == tlsx_pkg::KIND_DONE)
        else $error("second result slot misused");

    // a block-stopping error leaves the block marked failed
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld[0] && res0.kind == tlsx_pkg::KIND_ERROR && res0.last) |=> block_failed_reg)
        else $error("fatal error did not mark block failed");

    // nothing is reported while idle without a block start
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && !block_start) |-> res_vld == 2'b00)
        else $error("result produced while idle");

endmodule

### rtl/core/tlsx_res_fifo.sv
// Four-entry result queue: takes up to two results a cycle, hands out one unless res_stall is high.
// Depends on tlsx_pkg for the result type.
`timescale 1ns / 1ps

module tlsx_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_vld,
    input  tlsx_pkg::result_t push0,
    input  tlsx_pkg::result_t push1,
    output logic              room2,
    output logic              res_valid,
    input  logic              res_stall,
    output tlsx_pkg::result_t head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    tlsx_pkg::result_t entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              pop;
    logic [AW:0]       push_n;

    // status toward both sides
    assign room2     = count_reg <= (AW + 1)'(DEPTH - 2);
    assign res_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    assign push_n    = (AW + 1)'(push_vld[0]) + (AW + 1)'(push_vld[1]);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_n);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + push_n - (AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_vld[0])
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_vld[1])
        begin
            entry_reg[wr_ptr_reg + AW'(1)] <= push1;
        end
    end

    // never more entries than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW + 1)'(DEPTH))
        else $error("result queue overflow");

    // pushes only arrive while there is room for two
    assert property (@(posedge clk) disable iff (!rst_n)
        push_vld != 2'b00 |-> room2)
        else $error("push without room");

endmodule

### rtl/core/tls_extension_block_parser.sv
// Top level of the TLS extensions block parser: input stage, byte parser, result queue.
// Depends on tlsx_pkg, tlsx_core and tlsx_res_fifo.
`timescale 1ns / 1ps

// Takes one byte of a TLS extensions block per cycle and reports extension headers,
// server name type and host bytes, srtp protection profiles, errors and block completion.
// A byte is registered on acceptance and parsed once the result queue has room for two
// more results, which the parser then writes into it. Each byte yields zero, one or two results;
// they wait in a four-entry queue that drains one per cycle unless res_stall is high.
// The input stalls only while that queue has fewer than two free slots, so bytes flow
// at one per cycle as long as results are taken at least as fast as they are produced.

module tls_extension_block_parser #(
    parameter int MAX_PROFILES = tlsx_pkg::MAX_PROFILES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  data_byte,
    input  logic        block_start,
    input  logic [15:0] block_length,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  item_kind,
    output logic [15:0] ext_type,
    output logic [15:0] ext_length,
    output logic [15:0] item_value,
    output logic [2:0]  error_code,
    output logic        last_of_block
);

    logic              stg_valid_reg, stg_valid_next;
    logic [7:0]        stg_byte_reg;
    logic              stg_start_reg;
    logic [15:0]       stg_len_reg;
    logic              room2;
    logic              advance;
    logic              accept;
    logic [1:0]        res_vld;
    tlsx_pkg::result_t res0;
    tlsx_pkg::result_t res1;
    tlsx_pkg::result_t head;

    // input stage handshake
    assign advance        = stg_valid_reg && room2;
    assign src_stall      = stg_valid_reg && !room2;
    assign accept         = src_valid && !src_stall;
    assign stg_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stg_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_byte_reg  <= data_byte;
            stg_start_reg <= block_start;
            stg_len_reg   <= block_length;
        end
    end

    tlsx_core #(
        .MAX_PROFILES (MAX_PROFILES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .data_byte    (stg_byte_reg),
        .block_start  (stg_start_reg),
        .block_length (stg_len_reg),
        .res_vld      (res_vld),
        .res0         (res0),
        .res1         (res1)
    );

    tlsx_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (res_vld),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    // result fields
    assign item_kind     = head.kind;
    assign ext_type      = head.ext_type;
    assign ext_length    = head.ext_length;
    assign item_value    = head.value;
    assign error_code    = head.err;
    assign last_of_block = head.last;

endmodule
